// ----- rtl/symmetric_rank_k_update_core_macros.svh -----
// Assertion helpers shared by the RTL of the rank-k update core.
`ifndef SYMMETRIC_RANK_K_UPDATE_CORE_MACROS_SVH
`define SYMMETRIC_RANK_K_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SRK_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srk assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SRK_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srk assertion failed");

`endif

// ----- rtl/srk_pkg.sv -----
// ----------------------------------------------------------------------------
// srk_pkg
// Shared types and codes of the symmetric rank-k update core.
// ----------------------------------------------------------------------------
package srk_pkg;

   // input transaction kinds
   localparam logic [1:0] OP_WRITE_A = 2'd0;
   localparam logic [1:0] OP_WRITE_C = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   // floating-point unit operations
   localparam logic FOP_MUL = 1'b0;
   localparam logic FOP_ADD = 1'b1;

   // register indexes
   localparam logic [2:0] REG_ROW_MAJOR  = 3'd0;
   localparam logic [2:0] REG_USE_LOWER  = 3'd1;
   localparam logic [2:0] REG_TRANSPOSED = 3'd2;
   localparam logic [2:0] REG_ORDER_N    = 3'd3;
   localparam logic [2:0] REG_INNER_K    = 3'd4;
   localparam logic [2:0] REG_ALPHA      = 3'd5;
   localparam logic [2:0] REG_BETA       = 3'd6;

   localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
   localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
   localparam logic [31:0] FP_DEF_NAN = 32'hFFC0_0000;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

endpackage

// ----- rtl/symmetric_rank_k_update_core.sv -----
// ----------------------------------------------------------------------------
// symmetric_rank_k_update_core
// C = alpha*A*A^T + beta*C (or A^T*A) on one triangle, one shared FP unit.
// ----------------------------------------------------------------------------
// Write transactions (op 0, 1) are accepted while the sequencer is idle; tready stays low during a compute.
// A compute transaction emits n(n+1)/2 results; each element runs step by step on the
// shared three-stage FP unit (no transpose or transpose form, fewer steps with zero alpha,
// none with zero alpha and beta), and its result waits for output stalls to clear.
// Reset clears sequencer, output valid and registers; the A and C stores stay unknown.
`include "symmetric_rank_k_update_core_macros.svh"

module symmetric_rank_k_update_core #(
   parameter int MAX_N = 8,
   parameter int MAX_K = 8
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: row[2:0], col[5:3], value[37:6], zero pad[39:38]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // req_tuser: op[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: out_row[2:0], out_col[5:3], out_value[37:6], zero pad[39:38]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import srk_pkg::*;

   localparam int A_DIM   = (MAX_N > MAX_K) ? MAX_N : MAX_K;
   localparam int A_DEPTH = A_DIM * A_DIM;
   localparam int C_DEPTH = MAX_N * MAX_N;
   localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int CAW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
   localparam int DW      = $clog2(A_DIM + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CRD  = 4'd1;
   localparam logic [3:0] S_CGET = 4'd2;
   localparam logic [3:0] S_RDA1 = 4'd3;
   localparam logic [3:0] S_RDA2 = 4'd4;
   localparam logic [3:0] S_RDA3 = 4'd5;
   localparam logic [3:0] S_OP   = 4'd6;
   localparam logic [3:0] S_WAIT = 4'd7;
   localparam logic [3:0] S_EMIT = 4'd8;

   // arithmetic steps of one element
   localparam logic [2:0] ST_SCALE = 3'd0;  // c*beta
   localparam logic [2:0] ST_TA    = 3'd1;  // alpha*a1
   localparam logic [2:0] ST_PA    = 3'd2;  // t*a2
   localparam logic [2:0] ST_PT    = 3'd3;  // a1*a2
   localparam logic [2:0] ST_ACC   = 3'd4;  // acc+p
   localparam logic [2:0] ST_P1    = 3'd5;  // alpha*acc
   localparam logic [2:0] ST_P2    = 3'd6;  // beta*c
   localparam logic [2:0] ST_FIN   = 3'd7;  // t+p

   // ---------------- configuration registers ----------------
   logic        row_major_ff, use_lower_ff, transposed_ff;
   logic [3:0]  order_n_ff, inner_k_ff;
   logic [31:0] alpha_ff, beta_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         row_major_ff  <= 1'b0;
         use_lower_ff  <= 1'b0;
         transposed_ff <= 1'b0;
         order_n_ff    <= 4'd8;
         inner_k_ff    <= 4'd8;
         alpha_ff      <= FP_ONE;
         beta_ff       <= FP_ZERO;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ROW_MAJOR:  row_major_ff  <= csr_pwdata[0];
            REG_USE_LOWER:  use_lower_ff  <= csr_pwdata[0];
            REG_TRANSPOSED: transposed_ff <= csr_pwdata[0];
            REG_ORDER_N:    order_n_ff    <= csr_pwdata[3:0];
            REG_INNER_K:    inner_k_ff    <= csr_pwdata[3:0];
            REG_ALPHA:      alpha_ff      <= csr_pwdata;
            REG_BETA:       beta_ff       <= csr_pwdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROW_MAJOR:  csr_prdata = {31'd0, row_major_ff};
         REG_USE_LOWER:  csr_prdata = {31'd0, use_lower_ff};
         REG_TRANSPOSED: csr_prdata = {31'd0, transposed_ff};
         REG_ORDER_N:    csr_prdata = {28'd0, order_n_ff};
         REG_INNER_K:    csr_prdata = {28'd0, inner_k_ff};
         REG_ALPHA:      csr_prdata = alpha_ff;
         REG_BETA:       csr_prdata = beta_ff;
         default:        csr_prdata = 32'd0;
      endcase
   end

   // effective shape: row-major flips triangle and transpose
   logic          lower, trans, alpha0, beta0;
   logic [DW-1:0] n_eff, k_eff;

   assign lower  = use_lower_ff ^ row_major_ff;
   assign trans  = transposed_ff ^ row_major_ff;
   assign alpha0 = (alpha_ff[30:0] == 31'd0);
   assign beta0  = (beta_ff[30:0] == 31'd0);
   assign n_eff  = (32'(order_n_ff) > MAX_N) ? DW'(MAX_N) : DW'(order_n_ff);
   assign k_eff  = (32'(inner_k_ff) > MAX_K) ? DW'(MAX_K) : DW'(inner_k_ff);

   // view addressing: element (r,c) of the column-major view
   function automatic logic [AAW-1:0] a_addr(input logic rm, input logic [DW-1:0] r,
                                             input logic [DW-1:0] c);
      a_addr = rm ? AAW'(32'(c) * A_DIM + 32'(r)) : AAW'(32'(r) * A_DIM + 32'(c));
   endfunction

   function automatic logic [CAW-1:0] c_addr(input logic rm, input logic [DW-1:0] r,
                                             input logic [DW-1:0] c);
      c_addr = rm ? CAW'(32'(c) * MAX_N + 32'(r)) : CAW'(32'(r) * MAX_N + 32'(c));
   endfunction

   // ---------------- input transaction decode ----------------
   logic [1:0]  in_op;
   logic [2:0]  in_row, in_col;
   logic [31:0] in_value;
   logic        req_acc;

   assign in_op    = req_tuser;
   assign in_row   = req_tdata[2:0];
   assign in_col   = req_tdata[5:3];
   assign in_value = req_tdata[37:6];
   assign req_acc  = req_tvalid && req_tready;

   // ---------------- sequencer ----------------
   logic [3:0]    state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in, l_ff, l_in;
   logic [31:0]   c_ff, c_in, a1_ff, a1_in, a2_ff, a2_in;
   logic [31:0]   acc_ff, acc_in, t_ff, t_in, p_ff, p_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          emit_go, last_elem;
   logic [AAW-1:0] a_raddr, addr1, addr2;
   logic [CAW-1:0] c_raddr;
   logic [31:0]   a_rd_ff, c_rd_ff;
   logic          a_we, c_we;
   logic [AAW-1:0] a_waddr;
   logic [CAW-1:0] c_waddr;
   logic [31:0]   c_wdata;

   fpu_req_type   fpu_req;
   fpu_rsp_type   fpu_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign emit_go    = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign last_elem  = (j_ff == n_eff - DW'(1)) &&
                       (lower ? (i_ff == n_eff - DW'(1)) : (i_ff == j_ff));

   assign addr1   = trans ? a_addr(row_major_ff, l_ff, i_ff) : a_addr(row_major_ff, j_ff, l_ff);
   assign addr2   = trans ? a_addr(row_major_ff, l_ff, j_ff) : a_addr(row_major_ff, i_ff, l_ff);
   assign a_raddr = (state_ff == S_RDA2) ? addr2 : addr1;
   assign c_raddr = c_addr(row_major_ff, i_ff, j_ff);

   // memory writes: loads while idle, write-back of each updated element
   always_comb begin
      a_we    = req_acc && (in_op == OP_WRITE_A) &&
                (32'(in_row) < A_DIM) && (32'(in_col) < A_DIM);
      a_waddr = AAW'(32'(in_row) * A_DIM + 32'(in_col));
      if (emit_go) begin
         c_we    = 1'b1;
         c_waddr = c_raddr;
         c_wdata = acc_ff;
      end else begin
         c_we    = req_acc && (in_op == OP_WRITE_C) &&
                   (32'(in_row) < MAX_N) && (32'(in_col) < MAX_N);
         c_waddr = CAW'(32'(in_row) * MAX_N + 32'(in_col));
         c_wdata = in_value;
      end
   end

   logic [31:0] a_mem [A_DEPTH];
   logic [31:0] c_mem [C_DEPTH];

   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= in_value;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[c_waddr] <= c_wdata;
      end
      c_rd_ff <= c_mem[c_raddr];
   end

   // operand selection for the shared unit
   always_comb begin
      fpu_req.start = (state_ff == S_OP);
      fpu_req.op    = FOP_MUL;
      fpu_req.a     = c_ff;
      fpu_req.b     = beta_ff;
      unique case (step_ff)
         ST_SCALE: begin fpu_req.a = c_ff;     fpu_req.b = beta_ff; end
         ST_TA:    begin fpu_req.a = alpha_ff; fpu_req.b = a1_ff;   end
         ST_PA:    begin fpu_req.a = t_ff;     fpu_req.b = a2_ff;   end
         ST_PT:    begin fpu_req.a = a1_ff;    fpu_req.b = a2_ff;   end
         ST_ACC: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = acc_ff;
            fpu_req.b  = p_ff;
         end
         ST_P1:    begin fpu_req.a = alpha_ff; fpu_req.b = acc_ff;  end
         ST_P2:    begin fpu_req.a = beta_ff;  fpu_req.b = c_ff;    end
         ST_FIN: begin
            fpu_req.op = FOP_ADD;
            fpu_req.a  = t_ff;
            fpu_req.b  = p_ff;
         end
         default: ;
      endcase
   end

   srk_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      l_in         = l_ff;
      c_in         = c_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            // start a compute pass; an empty matrix emits nothing
            if (req_acc && (in_op == OP_COMPUTE) && (n_eff != DW'(0))) begin
               i_in     = DW'(0);
               j_in     = DW'(0);
               state_in = S_CRD;
            end
         end
         S_CRD: state_in = S_CGET;
         S_CGET: begin
            c_in = c_rd_ff;
            l_in = DW'(0);
            priority if (alpha0) begin
               if (beta0) begin
                  acc_in   = FP_ZERO;
                  state_in = S_EMIT;
               end else begin
                  step_in  = ST_SCALE;
                  state_in = S_OP;
               end
            end else if (!trans) begin
               step_in  = ST_SCALE;
               state_in = S_OP;
            end else begin
               acc_in = FP_ZERO;
               if (k_eff == DW'(0)) begin
                  step_in  = ST_P1;
                  state_in = S_OP;
               end else begin
                  state_in = S_RDA1;
               end
            end
         end
         S_RDA1: state_in = S_RDA2;
         S_RDA2: begin
            a1_in    = a_rd_ff;
            state_in = S_RDA3;
         end
         S_RDA3: begin
            a2_in    = a_rd_ff;
            step_in  = trans ? ST_PT : ST_TA;
            state_in = S_OP;
         end
         S_OP: state_in = S_WAIT;
         S_WAIT: begin
            if (fpu_rsp.done) begin
               state_in = S_OP;
               unique case (step_ff)
                  ST_SCALE: begin
                     acc_in = fpu_rsp.result;
                     if (alpha0 || (k_eff == DW'(0))) begin
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_RDA1;
                     end
                  end
                  ST_TA: begin t_in = fpu_rsp.result; step_in = ST_PA;  end
                  ST_PA: begin p_in = fpu_rsp.result; step_in = ST_ACC; end
                  ST_PT: begin p_in = fpu_rsp.result; step_in = ST_ACC; end
                  ST_ACC: begin
                     acc_in = fpu_rsp.result;
                     if (l_ff + DW'(1) < k_eff) begin
                        l_in     = l_ff + DW'(1);
                        state_in = S_RDA1;
                     end else if (trans) begin
                        step_in = ST_P1;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  ST_P1: begin t_in = fpu_rsp.result; step_in = ST_P2;  end
                  ST_P2: begin p_in = fpu_rsp.result; step_in = ST_FIN; end
                  ST_FIN: begin
                     acc_in   = fpu_rsp.result;
                     state_in = S_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         S_EMIT: begin
            // hold until the output register is free, then advance the walk
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_major_ff ? 3'(j_ff) : 3'(i_ff);
               rsp_col_in   = row_major_ff ? 3'(i_ff) : 3'(j_ff);
               rsp_value_in = acc_ff;
               rsp_last_in  = last_elem;
               if (last_elem) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_CRD;
                  if (lower) begin
                     if (i_ff + DW'(1) < n_eff) begin
                        i_in = i_ff + DW'(1);
                     end else begin
                        j_in = j_ff + DW'(1);
                        i_in = j_ff + DW'(1);
                     end
                  end else begin
                     if (i_ff < j_ff) begin
                        i_in = i_ff + DW'(1);
                     end else begin
                        j_in = j_ff + DW'(1);
                        i_in = DW'(0);
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_SCALE;
         i_ff         <= '0;
         j_ff         <= '0;
         l_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         l_ff         <= l_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_ff         <= c_in;
      a1_ff        <= a1_in;
      a2_ff        <= a2_in;
      acc_ff       <= acc_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- assertions ----------------
   `SRK_ASSERT_IMP(a_fpu_done_in_wait, clock, reset, fpu_rsp.done, state_ff == S_WAIT)
   `SRK_ASSERT_IMP(a_idle_fpu_quiet, clock, reset, state_ff == S_IDLE, !fpu_rsp.done)
   `SRK_ASSERT_NXT(a_last_returns_idle, clock, reset, emit_go && last_elem, state_ff == S_IDLE)

endmodule

// ----- rtl/srk_fpu.sv -----
// ----------------------------------------------------------------------------
// srk_fpu
// Single-precision multiply or add, round to nearest even, three stages.
// ----------------------------------------------------------------------------
module srk_fpu (
   input  logic                clock,
   input  logic                reset,
   input  srk_pkg::fpu_req_type req,
   output srk_pkg::fpu_rsp_type rsp
);
   import srk_pkg::*;

   // unpack
   logic        sa, sb;
   logic [7:0]  ea, eb, eae, ebe;
   logic [23:0] ma, mb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   assign sa     = req.a[31];
   assign sb     = req.b[31];
   assign ea     = req.a[30:23];
   assign eb     = req.b[30:23];
   assign eae    = (ea == 8'd0) ? 8'd1 : ea;
   assign ebe    = (eb == 8'd0) ? 8'd1 : eb;
   assign ma     = {ea != 8'd0, req.a[22:0]};
   assign mb     = {eb != 8'd0, req.b[22:0]};
   assign a_nan  = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
   assign b_nan  = (eb == 8'hFF) && (req.b[22:0] != 23'd0);
   assign a_inf  = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
   assign b_inf  = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
   assign a_zero = (req.a[30:0] == 31'd0);
   assign b_zero = (req.b[30:0] == 31'd0);

   // stage 1: product or aligned sum
   logic [47:0]        prod;
   logic               a_big, sx, sy, eff_sub;
   logic [7:0]         xe, ye, dexp;
   logic [23:0]        mx, my;
   logic [49:0]        mx50, my50, ys, sum50;
   logic               lost;
   logic [49:0]        m1;
   logic signed [10:0] x1;
   logic               sign1, zsign1, spec1;
   logic [31:0]        specv1;

   always_comb begin
      prod    = ma * mb;
      a_big   = req.a[30:0] >= req.b[30:0];
      sx      = a_big ? sa : sb;
      sy      = a_big ? sb : sa;
      xe      = a_big ? eae : ebe;
      ye      = a_big ? ebe : eae;
      mx      = a_big ? ma : mb;
      my      = a_big ? mb : ma;
      eff_sub = sx ^ sy;
      dexp    = xe - ye;
      mx50    = {1'b0, mx, 25'd0};
      my50    = {1'b0, my, 25'd0};
      if (dexp >= 8'd50) begin
         ys   = 50'd0;
         lost = (my != 24'd0);
      end else begin
         ys   = my50 >> dexp[5:0];
         lost = |(my50 & ~({50{1'b1}} << dexp[5:0]));
      end
      ys    = ys | {49'd0, lost};
      sum50 = eff_sub ? (mx50 - ys) : (mx50 + ys);

      spec1  = 1'b0;
      specv1 = FP_DEF_NAN;
      if (req.op == FOP_MUL) begin
         m1     = {prod, 2'b00};
         x1     = $signed({3'd0, eae}) + $signed({3'd0, ebe}) - 11'sd126;
         sign1  = sa ^ sb;
         zsign1 = sa ^ sb;
         priority if (a_nan) begin
            spec1  = 1'b1;
            specv1 = req.a | 32'h0040_0000;
         end else if (b_nan) begin
            spec1  = 1'b1;
            specv1 = req.b | 32'h0040_0000;
         end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            spec1  = 1'b1;
            specv1 = FP_DEF_NAN;
         end else if (a_inf || b_inf) begin
            spec1  = 1'b1;
            specv1 = {sa ^ sb, 31'h7F80_0000};
         end else begin
            spec1 = 1'b0;
         end
      end else begin
         m1     = sum50;
         x1     = $signed({3'd0, xe}) + 11'sd1;
         sign1  = sx;
         zsign1 = eff_sub ? 1'b0 : sx;
         priority if (a_nan) begin
            spec1  = 1'b1;
            specv1 = req.a | 32'h0040_0000;
         end else if (b_nan) begin
            spec1  = 1'b1;
            specv1 = req.b | 32'h0040_0000;
         end else if (a_inf && b_inf && (sa != sb)) begin
            spec1  = 1'b1;
            specv1 = FP_DEF_NAN;
         end else if (a_inf) begin
            spec1  = 1'b1;
            specv1 = req.a;
         end else if (b_inf) begin
            spec1  = 1'b1;
            specv1 = req.b;
         end else begin
            spec1 = 1'b0;
         end
      end
   end

   logic               s1_valid_ff;
   logic [49:0]        s1_m_ff;
   logic signed [10:0] s1_x_ff;
   logic               s1_sign_ff, s1_zsign_ff, s1_spec_ff;
   logic [31:0]        s1_specv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req.start;
      end
      s1_m_ff     <= m1;
      s1_x_ff     <= x1;
      s1_sign_ff  <= sign1;
      s1_zsign_ff <= zsign1;
      s1_spec_ff  <= spec1;
      s1_specv_ff <= specv1;
   end

   // stage 2: leading-zero count and normalize (or denormalize)
   logic [5:0]         lz;
   logic signed [10:0] xn, lsh, rsh;
   logic [49:0]        n2;
   logic [7:0]         e2;
   logic               ovf2;

   always_comb begin
      lz = 6'd0;
      for (int b = 0; b < 50; b++) begin
         if (s1_m_ff[b]) begin
            lz = 6'(49 - b);
         end
      end
      xn  = s1_x_ff - $signed({5'd0, lz});
      lsh = s1_x_ff - 11'sd1;
      rsh = 11'sd1 - s1_x_ff;
      if (xn >= 11'sd1) begin
         n2 = s1_m_ff << lz;
      end else if (s1_x_ff >= 11'sd1) begin
         n2 = s1_m_ff << lsh[5:0];
      end else if (rsh >= 11'sd50) begin
         n2 = {49'd0, |s1_m_ff};
      end else begin
         n2 = (s1_m_ff >> rsh[5:0]) |
              {49'd0, |(s1_m_ff & ~({50{1'b1}} << rsh[5:0]))};
      end
      ovf2 = xn >= 11'sd255;
      e2   = (xn >= 11'sd1 && !ovf2) ? xn[7:0] : 8'd0;
   end

   logic        s2_valid_ff, s2_zero_ff, s2_ovf_ff;
   logic [49:0] s2_n_ff;
   logic [7:0]  s2_e_ff;
   logic        s2_sign_ff, s2_zsign_ff, s2_spec_ff;
   logic [31:0] s2_specv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_zero_ff  <= (s1_m_ff == 50'd0);
      s2_ovf_ff   <= ovf2;
      s2_n_ff     <= n2;
      s2_e_ff     <= e2;
      s2_sign_ff  <= s1_sign_ff;
      s2_zsign_ff <= s1_zsign_ff;
      s2_spec_ff  <= s1_spec_ff;
      s2_specv_ff <= s1_specv_ff;
   end

   // stage 3: round; a carry walks into the exponent on its own
   logic [30:0] base3, rnd3;
   logic        up3;
   logic [31:0] res3;

   always_comb begin
      base3 = {s2_e_ff, s2_n_ff[48:26]};
      up3   = s2_n_ff[25] & ((|s2_n_ff[24:0]) | s2_n_ff[26]);
      rnd3  = base3 + {30'd0, up3};
      priority if (s2_spec_ff) begin
         res3 = s2_specv_ff;
      end else if (s2_zero_ff) begin
         res3 = {s2_zsign_ff, 31'd0};
      end else if (s2_ovf_ff) begin
         res3 = {s2_sign_ff, 31'h7F80_0000};
      end else begin
         res3 = {s2_sign_ff, rnd3};
      end
   end

   logic        done_ff;
   logic [31:0] result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= s2_valid_ff;
      end
      result_ff <= res3;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the symmetric rank-k update core. A bit-exact
// single-precision predictor runs beside the block. Results are compared
// in order with the predicted triangle over a sweep of register settings
// and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import srk_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored by the block
   localparam logic [2:0] REG_SPARE = 3'd7;   // past the last register
   localparam logic [31:0] FP_QNAN  = 32'hFFC0_0000;
   localparam logic [31:0] FP_INF   = 32'h7F80_0000;

   // -------------------------------------------------------------------------
   // Triangle predictor with its own copy of both stores and the registers
   // -------------------------------------------------------------------------
   class srk_scoreboard;
      typedef struct packed {
         bit [2:0]  row;
         bit [2:0]  col;
         bit [31:0] value;
         bit        last;
      } tri_elem_type;

      bit [31:0] a_mem [8][8];
      bit [31:0] c_mem [8][8];
      bit        row_major, use_lower, transposed;
      bit [3:0]  order_n, inner_k;
      bit [31:0] alpha, beta;
      tri_elem_type triangle_q[$];
      int        errors, results, computes, accepted;

      function new();
         row_major = 0; use_lower = 0; transposed = 0;
         order_n = 4'd8; inner_k = 4'd8;
         alpha = FP_ONE; beta = FP_ZERO;
      endfunction

      function void set_reg(bit [2:0] idx, bit [31:0] v);
         case (idx)
            REG_ROW_MAJOR:  row_major  = v[0];
            REG_USE_LOWER:  use_lower  = v[0];
            REG_TRANSPOSED: transposed = v[0];
            REG_ORDER_N:    order_n    = v[3:0];
            REG_INNER_K:    inner_k    = v[3:0];
            REG_ALPHA:      alpha      = v;
            REG_BETA:       beta       = v;
            default: ;
         endcase
      endfunction

      // normalize, round to nearest even and pack; value = sig * 2^(e-190)
      function bit [31:0] round_pack(bit s, int e, bit [63:0] sig);
         bit [63:0] m;
         bit [24:0] mant;
         int        sh;
         longint    total;
         m = sig;
         while (!m[63]) begin
            m = m << 1;
            e--;
         end
         if (e < 1) begin
            sh = 1 - e;
            if (sh > 63) m = {63'd0, |m};
            else m = (m >> sh) | {63'd0, |(m & ((64'd1 << sh) - 1))};
            e = 1;
         end
         mant = {1'b0, m[63:40]};
         if (m[39] && ((|m[38:0]) || mant[0])) mant++;
         total = (longint'(e - 1) << 23) + longint'(mant);
         if (total >= longint'(FP_INF)) return {s, FP_INF[30:0]};
         return {s, total[30:0]};
      endfunction

      function bit is_nan(bit [31:0] x);
         return x[30:23] == 8'hFF && x[22:0] != 0;
      endfunction

      function bit is_inf(bit [31:0] x);
         return x[30:23] == 8'hFF && x[22:0] == 0;
      endfunction

      function bit is_zero(bit [31:0] x);
         return x[30:0] == 0;
      endfunction

      function bit [31:0] fp_mul(bit [31:0] a, bit [31:0] b);
         bit        s;
         int        ea, eb;
         bit [23:0] ma, mb;
         bit [47:0] pr;
         s = a[31] ^ b[31];
         if (is_nan(a) || is_nan(b)) return FP_QNAN;
         if (is_inf(a) || is_inf(b)) begin
            if (is_zero(a) || is_zero(b)) return FP_QNAN;
            return {s, FP_INF[30:0]};
         end
         if (is_zero(a) || is_zero(b)) return {s, 31'd0};
         ea = (a[30:23] == 0) ? 1 : a[30:23];
         eb = (b[30:23] == 0) ? 1 : b[30:23];
         ma = {a[30:23] != 0, a[22:0]};
         mb = {b[30:23] != 0, b[22:0]};
         pr = ma * mb;
         return round_pack(s, ea + eb - 110, {16'd0, pr});
      endfunction

      function bit [31:0] fp_add(bit [31:0] a, bit [31:0] b);
         bit [31:0] t;
         int        ea, eb, d;
         bit [63:0] sa, sb, sum;
         if (is_nan(a) || is_nan(b)) return FP_QNAN;
         if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : FP_QNAN;
         if (is_inf(a)) return a;
         if (is_inf(b)) return b;
         if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
         if (is_zero(a)) return b;
         if (is_zero(b)) return a;
         // keep the larger magnitude in a
         if (a[30:0] < b[30:0]) begin
            t = a; a = b; b = t;
         end
         ea = (a[30:23] == 0) ? 1 : a[30:23];
         eb = (b[30:23] == 0) ? 1 : b[30:23];
         sa = {40'd0, a[30:23] != 0, a[22:0]} << 38;
         sb = {40'd0, b[30:23] != 0, b[22:0]} << 38;
         d = ea - eb;
         if (d > 63) sb = {63'd0, |sb};
         else if (d > 0) sb = (sb >> d) | {63'd0, |(sb & ((64'd1 << d) - 1))};
         sum = (a[31] == b[31]) ? sa + sb : sa - sb;
         if (sum == 0) return FP_ZERO;
         return round_pack(a[31], ea + 2, sum);
      endfunction

      function bit [31:0] a_at(int r, int c);
         return row_major ? a_mem[c][r] : a_mem[r][c];
      endfunction

      // one updated element of C, rounding every step on its own
      function bit [31:0] updated_entry(int i, int j, bit [31:0] c, int k, bit trn);
         bit [31:0] t, p;
         if (is_zero(alpha)) return is_zero(beta) ? FP_ZERO : fp_mul(c, beta);
         if (!trn) begin
            c = fp_mul(c, beta);
            for (int l = 0; l < k; l++) begin
               t = fp_mul(alpha, a_at(j, l));
               p = fp_mul(t, a_at(i, l));
               c = fp_add(c, p);
            end
            return c;
         end
         t = FP_ZERO;
         for (int l = 0; l < k; l++) t = fp_add(t, fp_mul(a_at(l, i), a_at(l, j)));
         return fp_add(fp_mul(alpha, t), fp_mul(beta, c));
      endfunction

      function void note_input(bit [1:0] op, bit [2:0] row, bit [2:0] col, bit [31:0] v);
         int        n, k, lo_i, hi_i;
         bit        lower, trn;
         bit [31:0] r;
         tri_elem_type e;
         accepted++;
         case (op)
            OP_WRITE_A: a_mem[row][col] = v;
            OP_WRITE_C: c_mem[row][col] = v;
            OP_COMPUTE: begin
               computes++;
               n = (order_n > 8) ? 8 : order_n;
               k = (inner_k > 8) ? 8 : inner_k;
               lower = use_lower ^ row_major;
               trn   = transposed ^ row_major;
               for (int j = 0; j < n; j++) begin
                  lo_i = lower ? j : 0;
                  hi_i = lower ? n : j + 1;
                  for (int i = lo_i; i < hi_i; i++) begin
                     if (row_major) begin
                        r = updated_entry(i, j, c_mem[j][i], k, trn);
                        c_mem[j][i] = r;
                     end else begin
                        r = updated_entry(i, j, c_mem[i][j], k, trn);
                        c_mem[i][j] = r;
                     end
                     e.row   = row_major ? 3'(j) : 3'(i);
                     e.col   = row_major ? 3'(i) : 3'(j);
                     e.value = r;
                     e.last  = 0;
                     triangle_q.push_back(e);
                  end
               end
               if (n > 0) triangle_q[$].last = 1;
            end
            default: ;
         endcase
      endfunction

      function void check_result(bit [2:0] row, bit [2:0] col, bit [31:0] v, bit last);
         tri_elem_type e;
         results++;
         if (triangle_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result row %0d col %0d value %h last %b",
                        row, col, v, last);
            return;
         end
         e = triangle_q.pop_front();
         if (e.row != row || e.col != col || e.value != v || e.last != last) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: result %0d exp (%0d,%0d) %h last %b, got (%0d,%0d) %h last %b",
                        results, e.row, e.col, e.value, e.last, row, col, v, last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // row[2:0], col[5:3], value[37:6], pad[39:38]
   logic [1:0]  req_tuser = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // out_row[2:0], out_col[5:3], out_value[37:6], pad
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   initial begin
      forever #6 clock = ~clock;
   end

   symmetric_rank_k_update_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   srk_scoreboard triangle_sb = new();

   int send_idle_pct  = 0;    // chance per cycle that the sender holds back
   int recv_stall_pct = 0;    // chance per cycle that the receiver stalls
   bit hold_request   = 0;    // ask the receiver for one long hold-off
   int hold_left      = 0;

   // Receiver: drop tready at random, or for one long stretch on request.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Sample each result transaction at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         triangle_sb.check_result(rsp_tdata[2:0], rsp_tdata[5:3], rsp_tdata[37:6], rsp_tlast);
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #30_000_000;
      $display("FAIL symmetric_rank_k_update_core");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------
   // Offer one input transaction; hold it until the block takes it.
   task automatic send_item(bit [1:0] op, bit [2:0] row, bit [2:0] col, bit [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, v, col, row};
      do @(posedge clock); while (!req_tready);
      triangle_sb.note_input(op, row, col, v);
   endtask

   // Release valid once the stream of transactions pauses.
   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Setup cycle, then access cycle; the register takes the value at its end.
   task automatic write_reg(bit [2:0] idx, bit [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      triangle_sb.set_reg(idx, v);
   endtask

   // Wait until every predicted element has come out, then let the block settle.
   task automatic drain();
      while (triangle_sb.triangle_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Random single-precision word: mostly moderate, sometimes any finite value.
   function automatic bit [31:0] rand_float();
      bit [7:0] ex;
      if ($urandom_range(9) == 0) ex = 8'($urandom_range(254));
      else ex = 8'($urandom_range(134, 120));
      return {1'($urandom_range(1)), ex, 23'($urandom)};
   endfunction

   // Random store write, compute request or ignored noise; returns 1 if it counts as an item.
   task automatic send_random_item(output bit counted);
      int pick;
      pick = $urandom_range(99);
      counted = 1;
      if (pick < 15) send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      else if (pick < 20) begin
         send_item(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom);
         counted = 0;
      end else if (pick < 60) send_item(OP_WRITE_A, 3'($urandom), 3'($urandom), rand_float());
      else send_item(OP_WRITE_C, 3'($urandom), 3'($urandom), rand_float());
   endtask

   // -------------------------------------------------------------------------
   // Register settings swept phase by phase
   // -------------------------------------------------------------------------
   typedef struct packed {
      bit        row_major, use_lower, transposed;
      bit [3:0]  order_n, inner_k;
      bit [31:0] alpha, beta;
   } csr_set_type;

   csr_set_type settings [10] = '{
      '{0, 0, 0, 4'd8,  4'd8,  32'h3F80_0000, 32'h0000_0000},
      '{0, 1, 0, 4'd3,  4'd4,  32'hBFC0_0000, 32'h3F00_0000},
      '{0, 0, 1, 4'd8,  4'd8,  32'h4000_0000, 32'h3F80_0000},
      '{1, 0, 0, 4'd5,  4'd2,  32'h3E80_0000, 32'hC000_0000},
      '{1, 1, 1, 4'd15, 4'd15, 32'h3DCC_CCCD, 32'hC049_0FDB},  // both sizes saturate
      '{0, 1, 1, 4'd0,  4'd3,  32'h3F80_0000, 32'h3F80_0000},  // empty matrix
      '{0, 0, 0, 4'd4,  4'd0,  32'h3F80_0000, 32'h4040_0000},  // no inner terms
      '{1, 0, 1, 4'd6,  4'd8,  32'h8000_0000, 32'h0000_0000},  // zero alpha, zero beta
      '{0, 1, 0, 4'd7,  4'd5,  32'h0000_0000, 32'h3FC0_0000},  // zero alpha, scale only
      '{1, 1, 0, 4'd2,  4'd1,  32'h7F00_0000, 32'h0040_0000}   // overflow, subnormal beta
   };

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      bit counted;
      int done_items;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill both stores so no compute ever reads an unwritten entry.
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++) begin
            send_item(OP_WRITE_A, 3'(r), 3'(c), rand_float());
            send_item(OP_WRITE_C, 3'(r), 3'(c), rand_float());
         end
      // Field extremes: largest and smallest magnitudes, signed zero.
      send_item(OP_WRITE_A, 3'd0, 3'd0, 32'h0000_0001);
      send_item(OP_WRITE_A, 3'd7, 3'd7, 32'hFF7F_FFFF);
      send_item(OP_WRITE_A, 3'd7, 3'd0, 32'h7F7F_FFFF);
      send_item(OP_WRITE_C, 3'd0, 3'd7, 32'h8000_0000);
      send_item(OP_WRITE_C, 3'd7, 3'd7, 32'h0080_0000);
      send_item(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      stop_sending();
      drain();
      // A write past the last register must change nothing.
      write_reg(REG_SPARE, 32'hFFFF_FFFF);

      for (int ph = 0; ph < 10; ph++) begin
         write_reg(REG_ROW_MAJOR,  settings[ph].row_major);
         write_reg(REG_USE_LOWER,  settings[ph].use_lower);
         write_reg(REG_TRANSPOSED, settings[ph].transposed);
         write_reg(REG_ORDER_N,    settings[ph].order_n);
         write_reg(REG_INNER_K,    settings[ph].inner_k);
         write_reg(REG_ALPHA,      settings[ph].alpha);
         write_reg(REG_BETA,       settings[ph].beta);

         // Rotate idle patterns: none, slow sender, slow receiver, both.
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
         endcase
         // Back up the output while the sender keeps pushing.
         if (ph == 2) hold_request = 1;

         send_item(OP_COMPUTE, 3'd7, 3'd0, 32'h0);
         if (ph == 2) send_item(OP_COMPUTE, 3'd0, 3'd7, 32'hFFFF_FFFF);
         done_items = 0;
         while (done_items < 8) begin
            send_random_item(counted);
            done_items += counted;
         end
         send_item(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
         stop_sending();
         drain();
      end

      $display("Run covered %0d input transactions, %0d compute requests, %0d results",
               triangle_sb.accepted, triangle_sb.computes, triangle_sb.results);
      $display("Settings swept: both layouts, both triangles, both forms, zero sizes");
      if (triangle_sb.errors == 0 && triangle_sb.triangle_q.size() == 0) begin
         $display("PASS symmetric_rank_k_update_core");
      end else begin
         $display("Mismatches: %0d, missing results: %0d",
                  triangle_sb.errors, triangle_sb.triangle_q.size());
         $display("FAIL symmetric_rank_k_update_core");
      end
      $finish;
   end

endmodule
